@@ rtl/assert_macros.svh @@
// Assertion macros used by huffman_code_builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcb assertion failed");
`define HCB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcb assertion failed");
`else
`define HCB_ASSERT_IMP(label, ante, cons)
`define HCB_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/hcb_pkg.sv @@
// Package with constants, types and state codes of the Huffman code builder.
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int WEIGHT_IN_W     = 16;
  localparam int SYM_W           = 6;
  localparam int CODE_W          = 63;
  localparam int LEN_W           = 6;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_DRAIN = 9'b000000100,
    S_W1    = 9'b000001000,
    S_W2    = 9'b000010000,
    S_W3    = 9'b000100000,
    S_EMIT  = 9'b001000000,
    S_UP    = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic parentless;
  } scan_ctl_t;

  typedef struct packed {
    logic weight;
    logic left;
    logic parent;
  } mem_we_t;

endpackage

@@ rtl/hcb_if.sv @@
// Handshake channels for weight input and code output.
interface hcb_in_if;
  import hcb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_IN_W-1:0] weight;
  logic                   last;
  modport source (output valid, weight, last, input ready);
  modport sink (input valid, weight, last, output ready);
endinterface

interface hcb_out_if;
  import hcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  symbol_index;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              last_code;
  modport source (output valid, symbol_index, code_bits, code_length, last_code,
                  input ready);
  modport sink (input valid, symbol_index, code_bits, code_length, last_code,
                output ready);
endinterface

@@ rtl/hcb_node_mem.sv @@
// Node store: weight, parent and left-child memories sharing one read address.
module hcb_node_mem #(
  parameter int IDX_W  = 7,
  parameter int NODE_W = 22
) (
  input  logic              clk,
  input  hcb_pkg::mem_we_t  we,
  input  logic [IDX_W-1:0]  waddr_node,
  input  logic [IDX_W-1:0]  waddr_parent,
  input  logic [NODE_W-1:0] wdata_weight,
  input  logic [IDX_W-1:0]  wdata_left,
  input  logic [IDX_W-1:0]  wdata_parent,
  input  logic [IDX_W-1:0]  raddr,
  output logic [NODE_W-1:0] rdata_weight,
  output logic [IDX_W-1:0]  rdata_left,
  output logic [IDX_W-1:0]  rdata_parent
);
  import hcb_pkg::*;

  localparam int DEPTH = 1 << IDX_W;

  logic [NODE_W-1:0] weight_mem [0:DEPTH-1];
  logic [IDX_W-1:0]  left_mem   [0:DEPTH-1];
  logic [IDX_W-1:0]  parent_mem [0:DEPTH-1];

  // Write ports
  always_ff @(posedge clk) begin
    if (we.weight) begin
      weight_mem[waddr_node] <= wdata_weight;
    end
    if (we.left) begin
      left_mem[waddr_node] <= wdata_left;
    end
    if (we.parent) begin
      parent_mem[waddr_parent] <= wdata_parent;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_weight <= weight_mem[raddr];
    rdata_left   <= left_mem[raddr];
    rdata_parent <= parent_mem[raddr];
  end

endmodule

@@ rtl/hcb_min_scan.sv @@
// Running search for the two parentless nodes of least weight.
module hcb_min_scan #(
  parameter int IDX_W  = 7,
  parameter int NODE_W = 22
) (
  input  logic              clk,
  input  hcb_pkg::scan_ctl_t ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [NODE_W-1:0] weight,
  output logic [IDX_W-1:0]  min_a,
  output logic [IDX_W-1:0]  min_b,
  output logic [NODE_W-1:0] min_wa,
  output logic [NODE_W-1:0] min_wb
);
  import hcb_pkg::*;

  logic va;
  logic vb;

  // Keep the lowest index on ties: only a strictly smaller weight displaces
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (ctl.valid && ctl.parentless) begin
      if (!va || weight < min_wa) begin
        min_b  <= min_a;
        min_wb <= min_wa;
        vb     <= va;
        min_a  <= idx;
        min_wa <= weight;
        va     <= 1'b1;
      end else if (!vb || weight < min_wb) begin
        min_b  <= idx;
        min_wb <= weight;
        vb     <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/huffman_code_builder.sv @@
// Huffman code builder: weight loading, tree build by scans, code emission.
//
// Channels: in carries one symbol weight per beat (weight, last); the beat
// with last high closes the set. out carries one beat per symbol, in symbol
// order: symbol_index, code_bits (right-aligned, root bit most significant,
// left edge 0), code_length, and last_code on the final symbol.
// Weights past MAX_SYMBOLS are dropped. For n symbols the build does n-1
// merges; merge k (new node n+k) scans nodes 1..n+k-1 at one node per
// cycle through the single memory read port, then passes through S_DRAIN
// and the write-back states S_W1, S_W2 and S_W3. Each code is then made in
// steps: the leaf read is issued, the leaf is read, the walk goes up one
// tree level per step to the root, and the output register is loaded.
// in is not ready during build and emission; it returns after the final
// code is loaded into the output register, even if that beat still waits.
// A stalled receiver holds the current code beat; the walk of the next code
// still runs and then waits in S_OUT until the output register is free.
// Reset (rst, synchronous) returns to loading with an empty set; node
// memories need no clearing, every entry used is written before it is read.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
  parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  hcb_in_if.sink   in,
  hcb_out_if.source out
);
  import hcb_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W    = $clog2(2 * MAX_SYMBOLS);
  localparam int CNT_W    = $clog2(MAX_SYMBOLS + 1);
  localparam int NODE_W   = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int LOAD_W   = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  node_i;
  logic [IDX_W-1:0]  scan_j;
  logic [IDX_W-1:0]  sym;
  logic              pend_valid;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              first;
  logic [IDX_W-1:0]  child;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;

  logic              o_valid;
  logic [SYM_W-1:0]  o_sym;
  logic [CODE_W-1:0] o_code;
  logic [LEN_W-1:0]  o_len;
  logic              o_last;

  mem_we_t           we;
  logic [IDX_W-1:0]  waddr_node;
  logic [IDX_W-1:0]  waddr_parent;
  logic [NODE_W-1:0] wdata_weight;
  logic [IDX_W-1:0]  wdata_left;
  logic [IDX_W-1:0]  wdata_parent;
  logic [IDX_W-1:0]  raddr;
  logic [NODE_W-1:0] rdata_weight;
  logic [IDX_W-1:0]  rdata_left;
  logic [IDX_W-1:0]  rdata_parent;

  scan_ctl_t         scan_ctl;
  logic [IDX_W-1:0]  min_a;
  logic [IDX_W-1:0]  min_b;
  logic [NODE_W-1:0] min_wa;
  logic [NODE_W-1:0] min_wb;

  logic              in_beat;
  logic              room;
  logic [IDX_W-1:0]  count_x;
  logic [IDX_W-1:0]  last_node;
  logic              out_free;
  logic              up_bit;
  logic [CODE_W-1:0] code_next;
  logic [LEN_W-1:0]  len_next;
  logic              walk_done;

  hcb_node_mem #(.IDX_W(IDX_W), .NODE_W(NODE_W)) u_mem (
    .clk          (clk),
    .we           (we),
    .waddr_node   (waddr_node),
    .waddr_parent (waddr_parent),
    .wdata_weight (wdata_weight),
    .wdata_left   (wdata_left),
    .wdata_parent (wdata_parent),
    .raddr        (raddr),
    .rdata_weight (rdata_weight),
    .rdata_left   (rdata_left),
    .rdata_parent (rdata_parent)
  );

  hcb_min_scan #(.IDX_W(IDX_W), .NODE_W(NODE_W)) u_scan (
    .clk    (clk),
    .ctl    (scan_ctl),
    .idx    (rd_addr_q),
    .weight (rdata_weight),
    .min_a  (min_a),
    .min_b  (min_b),
    .min_wa (min_wa),
    .min_wb (min_wb)
  );

  assign in.ready  = (state == S_LOAD);
  assign in_beat   = in.valid && in.ready;
  assign room      = (count < CNT_W'(MAX_SYMBOLS));
  assign count_x   = IDX_W'(count);
  assign last_node = (count_x << 1) - IDX_W'(1);
  assign out_free  = !o_valid || out.ready;

  assign out.valid        = o_valid;
  assign out.symbol_index = o_sym;
  assign out.code_bits    = o_code;
  assign out.code_length  = o_len;
  assign out.last_code    = o_last;

  // Feed the scan unit with the node read in the previous cycle
  assign scan_ctl.clear      = (state == S_LOAD) || (state == S_W3);
  assign scan_ctl.valid      = pend_valid;
  assign scan_ctl.parentless = (rdata_parent == '0);

  // Walk step: compare the parent's left child with the node below it
  assign up_bit    = (rdata_left != child);
  assign code_next = first ? code : (code | (CODE_W'(up_bit) << len));
  assign len_next  = first ? len : (len + LEN_W'(1));
  assign walk_done = (rdata_parent == '0) || (len_next == LEN_W'(CODE_W));

  // Select the read address
  always_comb begin
    unique case (state)
      S_SCAN:  raddr = scan_j;
      S_EMIT:  raddr = sym;
      S_UP:    raddr = rdata_parent;
      default: raddr = '0;
    endcase
  end

  // Select memory writes: leaf load, then merge write-back in three beats
  always_comb begin
    we           = '0;
    waddr_node   = node_i;
    waddr_parent = node_i;
    wdata_weight = min_wa + min_wb;
    wdata_left   = min_a;
    wdata_parent = node_i;
    unique case (state)
      S_LOAD: begin
        we.weight    = in_beat && room;
        we.left      = in_beat && room;
        we.parent    = in_beat && room;
        waddr_node   = count_x + IDX_W'(1);
        waddr_parent = count_x + IDX_W'(1);
        wdata_weight = NODE_W'(in.weight[LOAD_W-1:0]);
        wdata_left   = '0;
        wdata_parent = '0;
      end
      S_W1: begin
        we.weight    = 1'b1;
        we.left      = 1'b1;
        we.parent    = 1'b1;
        waddr_parent = min_a;
      end
      S_W2: begin
        we.parent    = 1'b1;
        waddr_parent = min_b;
      end
      S_W3: begin
        we.parent    = 1'b1;
        wdata_parent = '0;
      end
      default: begin
        we = '0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    rd_addr_q  <= raddr;
    pend_valid <= (state == S_SCAN);
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      // Drop a taken beat unless the output register loads a new one
      if (out.ready && (state != S_OUT)) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (in.last) begin
              sym    <= IDX_W'(1);
              node_i <= count_x + IDX_W'(room ? 2 : 1);
              scan_j <= IDX_W'(1);
              if ((room ? count + CNT_W'(1) : count) == CNT_W'(1)) begin
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          scan_j <= scan_j + IDX_W'(1);
          if (scan_j == node_i - IDX_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_W1;
        S_W1:    state <= S_W2;
        S_W2:    state <= S_W3;
        S_W3: begin
          scan_j <= IDX_W'(1);
          if (node_i == last_node) begin
            state <= S_EMIT;
          end else begin
            node_i <= node_i + IDX_W'(1);
            state  <= S_SCAN;
          end
        end
        S_EMIT: begin
          first <= 1'b1;
          child <= sym;
          code  <= '0;
          len   <= '0;
          state <= S_UP;
        end
        S_UP: begin
          first <= 1'b0;
          child <= rd_addr_q;
          code  <= code_next;
          len   <= len_next;
          if (walk_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_sym   <= SYM_W'(sym - IDX_W'(1));
            o_code  <= code;
            o_len   <= len;
            o_last  <= (sym == count_x);
            if (sym == count_x) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              sym   <= sym + IDX_W'(1);
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `HCB_ASSERT_IMP(a_merge_pair, state == S_W1, (min_a != min_b) && (min_a != '0) && (min_b != '0))
  `HCB_ASSERT_IMP(a_walk_internal, (state == S_UP) && !first, rd_addr_q > count_x)
  `HCB_ASSERT_IMP(a_scan_below_new, state == S_SCAN, scan_j < node_i)
  `HCB_ASSERT_NXT(a_last_closes, in_beat && in.last, state != S_LOAD)

endmodule

@@ bench/tb_huffman_code_builder.sv @@
// Testbench for huffman_code_builder: directed and random weight sets checked against a tree-building predictor.
`timescale 1ns / 1ps

module tb_huffman_code_builder;
  import hcb_pkg::*;

  typedef struct {
    logic [WEIGHT_IN_W-1:0] weight;
    logic                   last;
  } weight_beat_t;

  typedef struct {
    logic [SYM_W-1:0]  symbol_index;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              last_code;
  } code_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcb_in_if  in_ch ();
  hcb_out_if out_ch ();

  huffman_code_builder DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always #1 clk = ~clk;

  weight_beat_t weight_queue[$];
  code_beat_t   code_queue[$];
  int           error_count = 0;
  int           code_beats  = 0;

  // Predictor state: the weights of the set being loaded.
  logic [31:0] set_weight[128];
  int          set_count = 0;

  // Store one weight; on the closing beat build the tree and queue the codes.
  task automatic predict_codes(input logic [WEIGHT_IN_W-1:0] w, input logic lst);
    logic [31:0] nw[128];
    int          par[128];
    int          lft[128];
    int          a, b, top, c, f, len;
    bit          va, vb;
    logic [CODE_W-1:0] code;
    code_beat_t  cb;
    if (set_count < MAX_SYMBOLS_DEF) begin
      set_count++;
      set_weight[set_count] = 32'(w);
    end
    if (!lst) return;
    for (int j = 0; j < 128; j++) begin
      nw[j] = set_weight[j];
      par[j] = 0;
      lft[j] = 0;
    end
    // Merge the two lightest parentless nodes, lower index first on ties.
    for (int i = set_count + 1; i <= 2 * set_count - 1; i++) begin
      a = 0; b = 0; va = 0; vb = 0;
      top = i - 1;
      for (int j = 1; j <= top; j++) begin
        if (par[j] != 0) continue;
        if (!va || nw[j] < nw[a]) begin
          b = a; vb = va; a = j; va = 1;
        end else if (!vb || nw[j] < nw[b]) begin
          b = j; vb = 1;
        end
      end
      par[a] = i;
      par[b] = i;
      lft[i] = a;
      nw[i] = nw[a] + nw[b];
    end
    // Walk each leaf to the root, filling code bits from the LSB up.
    for (int i = 1; i <= set_count; i++) begin
      code = '0; len = 0; c = i; f = par[i];
      while (f != 0 && len < 63) begin
        if (lft[f] != c) code[len] = 1'b1;
        len++;
        c = f;
        f = par[f];
      end
      cb.symbol_index = SYM_W'(i - 1);
      cb.code_bits    = code;
      cb.code_length  = LEN_W'(len);
      cb.last_code    = (i == set_count);
      code_queue.push_back(cb);
    end
    set_count = 0;
  endtask

  // Driver: offer queued weights with random gaps, burst stretches between.
  int  send_gap = 0;
  int  sent     = 0;
  bit  burst_tx = 0;
  weight_beat_t cur;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid  <= 1'b0;
      in_ch.weight <= '0;
      in_ch.last   <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_codes(in_ch.weight, in_ch.last);
        sent++;
        if (sent % 40 == 0) burst_tx = ~burst_tx;
      end
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (weight_queue.size() > 0) begin
        cur = weight_queue.pop_front();
        in_ch.weight <= cur.weight;
        in_ch.last   <= cur.last;
        in_ch.valid  <= 1'b1;
        send_gap     <= burst_tx ? 0 : $urandom_range(0, 12);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold: count it down on its own once enough beats are in.
  int  long_cnt  = 0;
  bit  long_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      long_cnt <= 0;
    end else if (long_cnt > 0) begin
      long_cnt <= long_cnt - 1;
    end else if (!long_done && code_beats >= 30) begin
      long_done <= 1'b1;
      long_cnt  <= 400;
    end
  end

  // Monitor: check each code beat, then draw the next stall.
  int  hold_cnt = 0;
  bit  burst_rx = 0;
  code_beat_t exp_beat;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        code_beats++;
        if (code_beats % 50 == 0) burst_rx = ~burst_rx;
        if (code_queue.size() == 0) begin
          $display("%0t: unexpected code beat sym %0d", $time, out_ch.symbol_index);
          error_count++;
        end else begin
          exp_beat = code_queue.pop_front();
          if (out_ch.symbol_index !== exp_beat.symbol_index) begin
            $display("%0t: symbol_index exp %0d got %0d", $time,
                     exp_beat.symbol_index, out_ch.symbol_index);
            error_count++;
          end
          if (out_ch.code_bits !== exp_beat.code_bits) begin
            $display("%0t: code_bits exp %h got %h (sym %0d)", $time,
                     exp_beat.code_bits, out_ch.code_bits, exp_beat.symbol_index);
            error_count++;
          end
          if (out_ch.code_length !== exp_beat.code_length) begin
            $display("%0t: code_length exp %0d got %0d (sym %0d)", $time,
                     exp_beat.code_length, out_ch.code_length, exp_beat.symbol_index);
            error_count++;
          end
          if (out_ch.last_code !== exp_beat.last_code) begin
            $display("%0t: last_code exp %0d got %0d (sym %0d)", $time,
                     exp_beat.last_code, out_ch.last_code, exp_beat.symbol_index);
            error_count++;
          end
        end
        hold_cnt     <= burst_rx ? 0 : $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else if (long_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt     <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Queue one set of n weights; kind picks the weight pattern.
  task automatic add_set(input int n, input int kind);
    weight_beat_t wb;
    int fa, fb, t;
    fa = 1; fb = 1;
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: wb.weight = 16'($urandom_range(0, 65535));
        1: wb.weight = 16'($urandom_range(0, 3));
        2: wb.weight = 16'hFFFF;
        default: begin
          wb.weight = fa[15:0];
          t = fa + fb; fa = fb; fb = (t > 65535) ? 65535 : t;
        end
      endcase
      wb.last = (k == n - 1);
      weight_queue.push_back(wb);
    end
  endtask

  initial begin
    int total, n;
    in_ch.valid  = 1'b0;
    in_ch.weight = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;

    // Directed: single symbol, zero and max weights, ties, deep tree.
    add_set(1, 2);
    add_set(2, 1);
    add_set(3, 2);
    weight_queue.push_back('{16'hFFFF, 1'b0});
    weight_queue.push_back('{16'h0000, 1'b0});
    weight_queue.push_back('{16'hFFFF, 1'b1});
    add_set(4, 1);
    add_set(10, 3);
    total = 23;

    // Random sets: mostly small, a few full or overflowing.
    add_set(64, 0);
    add_set(66, 1);
    total += 130;
    while (total < 410) begin
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = $urandom_range(11, 64);
        default: n = $urandom_range(2, 10);
      endcase
      add_set(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
      total += n;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (weight_queue.size() == 0 && !in_ch.valid && code_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && code_queue.size() == 0)
      $display("[huffman_code_builder] OK");
    else
      $display("[huffman_code_builder] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[huffman_code_builder] ERROR");
    $finish;
  end

endmodule
